### design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent may start with a delay operator
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error("implication check failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`endif

### design/tob_pkg.sv
// types and constants of the timed output bank
// no dependencies
`timescale 1ns / 1ps

package tob_pkg;

   localparam int NUM_CHANNELS   = 17;
   localparam int COUNT_WIDTH    = 16;
   localparam int OP_WIDTH       = 2;
   localparam int CHANNEL_WIDTH  = 5;
   localparam int DURATION_WIDTH = 16;
   localparam int OUT_WIDTH      = 17;
   localparam int CH_IDX_WIDTH   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CH_CMP_WIDTH   = CHANNEL_WIDTH + 1;
   localparam int VEC_WIDTH      = (NUM_CHANNELS > OUT_WIDTH) ? NUM_CHANNELS : OUT_WIDTH;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_PLAIN_SET = 2'd0,
      OP_TIMED_SET = 2'd1,
      OP_GET_LEVEL = 2'd2,
      OP_TICK      = 2'd3
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic [CHANNEL_WIDTH-1:0]  channel;
      logic                      level;
      logic [DURATION_WIDTH-1:0] duration;
   } req_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] pin_levels;
      logic                 read_level;
      logic                 bad_channel;
      logic [OUT_WIDTH-1:0] reverted_mask;
   } rsp_type;

endpackage

### design/timed_output_bank.sv
// timed output bank: levels, return levels and revert countdowns per output
// depends on tob_pkg
`timescale 1ns / 1ps

// Usage
// A request is transferred on a rising edge with start high and busy low.
// req_data carries the operation (plain set, timed set, get level, tick),
// the channel, the level and the duration in half-second ticks.
// busy stays low: a request can be transferred in every cycle.
// Each request gives one response, shown on rsp_data for exactly one cycle
// with rsp_strobe high, after it has passed the request register and then
// the update logic into the response register. Throughput is one request
// per cycle; the state update of one request is done before the next
// request reaches the update logic.
// The receiver cannot hold responses off, so nothing waits or queues.
// Synchronous reset clears all levels and countdowns to zero and drops any
// request in flight; no response follows a request cut off by reset.
// A set or get addressing a channel beyond the bank raises bad_channel and
// leaves the state as it is.

module timed_output_bank (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  tob_pkg::req_type req_data,
   output logic             rsp_strobe,
   output tob_pkg::rsp_type rsp_data
);

   localparam logic [tob_pkg::CH_CMP_WIDTH-1:0] CH_LIMIT =
      tob_pkg::CH_CMP_WIDTH'(tob_pkg::NUM_CHANNELS);
   localparam logic [tob_pkg::COUNT_WIDTH-1:0] COUNT_ONE = tob_pkg::COUNT_WIDTH'(1);
   localparam logic [tob_pkg::COUNT_WIDTH-1:0] COUNT_ZERO = '0;

   logic                                 req_valid_ff;
   tob_pkg::req_type                     req_ff;
   logic [tob_pkg::NUM_CHANNELS-1:0]     current_level_ff;
   logic [tob_pkg::NUM_CHANNELS-1:0]     current_level_in;
   logic [tob_pkg::NUM_CHANNELS-1:0]     return_level_ff;
   logic [tob_pkg::NUM_CHANNELS-1:0]     return_level_in;
   logic [tob_pkg::COUNT_WIDTH-1:0]      countdown_ff [tob_pkg::NUM_CHANNELS];
   logic [tob_pkg::COUNT_WIDTH-1:0]      countdown_in [tob_pkg::NUM_CHANNELS];
   logic                                 rsp_strobe_ff;
   tob_pkg::rsp_type                     rsp_data_ff;
   tob_pkg::rsp_type                     rsp_data_in;
   logic [tob_pkg::NUM_CHANNELS-1:0]     reverted;
   logic [tob_pkg::VEC_WIDTH-1:0]        pin_wide;
   logic [tob_pkg::VEC_WIDTH-1:0]        reverted_wide;
   logic [tob_pkg::CH_IDX_WIDTH-1:0]     ch_idx;
   logic                                 ch_ok;
   logic                                 read_bit;
   logic                                 bad_bit;

   assign busy = 1'b0;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
      req_ff <= req_data;
   end

   assign ch_idx = req_ff.channel[tob_pkg::CH_IDX_WIDTH-1:0];
   assign ch_ok  = {1'b0, req_ff.channel} < CH_LIMIT;

   always_comb begin
      current_level_in = current_level_ff;
      return_level_in  = return_level_ff;
      countdown_in     = countdown_ff;
      reverted         = '0;
      read_bit         = 1'b0;
      bad_bit          = 1'b0;
      if (req_valid_ff) begin
         if (req_ff.operation == tob_pkg::OP_TICK) begin
            for (int n = 0; n < tob_pkg::NUM_CHANNELS; n++) begin
               if (countdown_ff[n] != COUNT_ZERO) begin
                  countdown_in[n] = countdown_ff[n] - COUNT_ONE;
                  if (countdown_ff[n] == COUNT_ONE) begin
                     current_level_in[n] = return_level_ff[n];
                     reverted[n]         = 1'b1;
                  end
               end
            end
         end else if (!ch_ok) begin
            bad_bit = 1'b1;
         end else begin
            case (req_ff.operation)
               tob_pkg::OP_PLAIN_SET: begin
                  current_level_in[ch_idx] = req_ff.level;
                  return_level_in[ch_idx]  = req_ff.level;
               end
               tob_pkg::OP_TIMED_SET: begin
                  current_level_in[ch_idx] = req_ff.level;
                  countdown_in[ch_idx]     = tob_pkg::COUNT_WIDTH'(req_ff.duration);
               end
               tob_pkg::OP_GET_LEVEL: begin
                  read_bit = current_level_ff[ch_idx];
               end
               default: begin
                  read_bit = 1'b0;
               end
            endcase
         end
      end
   end

   // pad or trim to the response field width
   assign pin_wide      = tob_pkg::VEC_WIDTH'(current_level_in);
   assign reverted_wide = tob_pkg::VEC_WIDTH'(reverted);

   always_comb begin
      rsp_data_in.pin_levels    = pin_wide[tob_pkg::OUT_WIDTH-1:0];
      rsp_data_in.read_level    = read_bit;
      rsp_data_in.bad_channel   = bad_bit;
      rsp_data_in.reverted_mask = reverted_wide[tob_pkg::OUT_WIDTH-1:0];
   end

   // state and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         current_level_ff <= '0;
         return_level_ff  <= '0;
         for (int n = 0; n < tob_pkg::NUM_CHANNELS; n++) begin
            countdown_ff[n] <= '0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         current_level_ff <= current_level_in;
         return_level_ff  <= return_level_in;
         countdown_ff     <= countdown_in;
         rsp_strobe_ff    <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### design/tob_checker.sv
// port-level checks of the timed output bank, bound to timed_output_bank
// depends on tob_pkg, assert_macros.svh and timed_output_bank
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tob_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input tob_pkg::req_type req_data,
   input logic             rsp_strobe,
   input tob_pkg::rsp_type rsp_data
);

   logic req_fire;

   assign req_fire = start && !busy;

   // every transfer gives a response after the request and response registers
   `ASSERT_IMPLIES(a_rsp_follows, clock, reset, req_fire, ##2 rsp_strobe)
   // no response without a transfer through the request and response registers
   `ASSERT_IMPLIES(a_rsp_has_req, clock, reset, rsp_strobe, $past(req_fire, 2))
   // a rejected channel reads nothing and reverts nothing
   `ASSERT_IMPLIES(a_bad_quiet, clock, reset, rsp_strobe && rsp_data.bad_channel,
      (!rsp_data.read_level && rsp_data.reverted_mask == '0))
   // a get leaves the pin vector as it was
   `ASSERT_IMPLIES(a_get_keeps_pins, clock, reset,
      rsp_strobe && $past(rsp_strobe) && $past(req_data.operation, 2) == tob_pkg::OP_GET_LEVEL,
      rsp_data.pin_levels == $past(rsp_data.pin_levels))

endmodule

bind timed_output_bank tob_checker u_tob_checker (.*);
